### hw/rtl/assert_macros.svh
// Assertion shorthands shared by the RTL. Each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must be followed by another one on the next clock edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/mts_pkg.sv
`default_nettype none

package mts_pkg;

  localparam int MAX_BEATS    = 16;
  localparam int MAX_DIVISION = 8;
  localparam int FRAC_BITS    = 16;

  localparam int BPB_W      = 5;
  localparam int SUBDIV_W   = 4;
  localparam int SPT_W      = 36;
  localparam int PAT_W      = 32;
  localparam int CD_W       = 38;
  localparam int PH_W       = 16;
  localparam int KIND_W     = 3;
  localparam int BEATNUM_W  = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 36;

  // Dividend width of the shared divider: covers the phase dividend
  // (remainder of the tick times 2^16 plus the tick fraction).
  localparam int DVD_W = 21;
  localparam int CNT_W = $clog2(DVD_W + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_BEATS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SUBDIV   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPT      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN  = 2'd3;

  localparam logic [BPB_W-1:0]    BEATS_RST   = 5'd4;
  localparam logic [SUBDIV_W-1:0] SUBDIV_RST  = 4'd1;
  localparam logic [SPT_W-1:0]    SPT_RST     = 36'd1572864000;
  localparam logic [PAT_W-1:0]    PATTERN_RST = 32'hAAAA_AAAB;

  typedef struct packed {
    logic             start;
    logic [SPT_W-1:0] rem_init;
    logic [DVD_W-1:0] dividend;
    logic [CNT_W-1:0] nbits;
    logic [SPT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quot;
    logic [SPT_W-1:0] rem;
  } div_rsp_t;

endpackage

`default_nettype wire

### hw/rtl/metronome_tick_scheduler.sv
// Sequence: a running transaction steps through the states PREP, DIVN, FIRE, DIVL, FRAC, PHASE and OUT
// after acceptance; FRAC is skipped when the countdown ends the sample below zero.
// A stopped transaction (enable low or zero tick period) goes from PREP straight to OUT.
// One transaction at a time on the single shared restoring divider; the next one is
// accepted the cycle after the result register loads, which waits while a valid output is stalled.
// Synchronous active-low reset restores register defaults and clears countdown and tick state.
`default_nettype none

`include "assert_macros.svh"

module metronome_tick_scheduler #(
  parameter int MAX_BEATS    = mts_pkg::MAX_BEATS,
  parameter int MAX_DIVISION = mts_pkg::MAX_DIVISION
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            in_command,
  input  wire logic                            in_enable,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 out_running,
  output logic                                 out_fired,
  output logic [mts_pkg::KIND_W-1:0]           out_click_kind,
  output logic [mts_pkg::BEATNUM_W-1:0]        out_beat_number,
  output logic [mts_pkg::PH_W-1:0]             out_beat_phase,
  input  wire logic                            cfg_we,
  input  wire logic [mts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [mts_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int BEAT_W = $clog2(MAX_BEATS + 1);
  localparam int DIV_W  = $clog2(MAX_DIVISION + 1);
  localparam int TICKS  = MAX_BEATS * MAX_DIVISION;
  localparam int TICK_W = (TICKS > 1) ? $clog2(TICKS) : 1;
  localparam int TPB_W  = $clog2(TICKS + 1);
  localparam int SPT_W  = mts_pkg::SPT_W;
  localparam int CD_W   = mts_pkg::CD_W;
  localparam int SUM_W  = CD_W + 2;
  localparam int DVD_W  = mts_pkg::DVD_W;
  localparam int CNT_W  = mts_pkg::CNT_W;
  localparam int PH_W   = mts_pkg::PH_W;
  localparam int KIND_W = mts_pkg::KIND_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PREP  = 3'd1;
  localparam logic [2:0] ST_DIVN  = 3'd2;
  localparam logic [2:0] ST_FIRE  = 3'd3;
  localparam logic [2:0] ST_DIVL  = 3'd4;
  localparam logic [2:0] ST_FRAC  = 3'd5;
  localparam logic [2:0] ST_PHASE = 3'd6;
  localparam logic [2:0] ST_OUT   = 3'd7;

  localparam logic [KIND_W-1:0] KIND_NONE = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SUB  = 3'd4;

  localparam logic [PH_W:0]    PHASE_ONE  = (PH_W + 1)'(1) << PH_W;
  localparam logic [SUM_W-1:0] CD_DEC     = SUM_W'(64'd1 << mts_pkg::FRAC_BITS);
  localparam logic [CD_W-1:0]  CD_MIN     = {1'b1, {(CD_W - 1){1'b0}}};
  localparam logic [SUM_W-1:0] CD_MIN_X   = {{(SUM_W - CD_W + 1){1'b1}}, {(CD_W - 1){1'b0}}};

  // Control and architectural state.
  logic [2:0]                  state_r, state_nxt;
  logic [mts_pkg::BPB_W-1:0]   beats_cfg_r;
  logic [mts_pkg::SUBDIV_W-1:0] div_cfg_r;
  logic [SPT_W-1:0]            spt_r;
  logic [mts_pkg::PAT_W-1:0]   pat_r;
  logic                        prev_en_r, prev_en_nxt;
  logic [TICK_W-1:0]           next_r, next_nxt;
  logic [TICK_W-1:0]           last_r, last_nxt;
  logic signed [CD_W-1:0]      cd_r, cd_nxt;
  logic                        out_valid_r, out_valid_nxt;
  mts_pkg::div_req_t           dreq_r, dreq_nxt;
  mts_pkg::div_rsp_t           dsp;

  // Per-transaction working registers.
  logic                        en_r, en_nxt;
  logic [DIV_W-1:0]            div_r, div_nxt;
  logic [TPB_W-1:0]            tpb_r, tpb_nxt;
  logic [DIV_W-1:0]            m_r, m_nxt;
  logic                        res_run_r, res_run_nxt;
  logic                        res_fired_r, res_fired_nxt;
  logic [KIND_W-1:0]           res_kind_r, res_kind_nxt;
  logic [mts_pkg::BEATNUM_W-1:0] res_beat_r, res_beat_nxt;
  logic [PH_W-1:0]             res_phase_r, res_phase_nxt;

  logic                        out_run_r;
  logic                        out_fired_r;
  logic [KIND_W-1:0]           out_kind_r;
  logic [mts_pkg::BEATNUM_W-1:0] out_beat_r;
  logic [PH_W-1:0]             out_phase_r;

  logic                        in_accept;
  logic                        out_load;
  logic                        restart;
  logic                        stopped;
  logic [BEAT_W-1:0]           beats_c;
  logic [DIV_W-1:0]            div_c;
  logic [TPB_W-1:0]            tpb_c;
  logic [TICK_W-1:0]           next_w;
  logic [TICK_W-1:0]           last_w;
  logic signed [CD_W-1:0]      cd_cl;
  logic signed [CD_W-1:0]      spt_x;
  logic                        fire;
  logic [mts_pkg::PAT_W-1:0]   pat_sh;
  logic [KIND_W-1:0]           kind_c;
  logic [TPB_W-1:0]            next_inc;
  logic [TICK_W-1:0]           last_new;
  logic [SUM_W-1:0]            cd_x;
  logic [SUM_W-1:0]            add_x;
  logic [SUM_W-1:0]            cd_sum;
  logic                        cd_sat;
  logic [SPT_W-1:0]            frac_a;
  logic [PH_W:0]               frac_c;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign restart   = in_command || (in_enable && !prev_en_r);
  assign stopped   = !en_r || (spt_r == '0);

  // Bar geometry, saturated into the supported range.
  always_comb begin
    if (beats_cfg_r == '0) begin
      beats_c = BEAT_W'(1);
    end else if (32'(beats_cfg_r) > 32'(MAX_BEATS)) begin
      beats_c = BEAT_W'(MAX_BEATS);
    end else begin
      beats_c = BEAT_W'(beats_cfg_r);
    end
    if (div_cfg_r == '0) begin
      div_c = DIV_W'(1);
    end else if (32'(div_cfg_r) > 32'(MAX_DIVISION)) begin
      div_c = DIV_W'(MAX_DIVISION);
    end else begin
      div_c = DIV_W'(div_cfg_r);
    end
  end

  assign tpb_c  = TPB_W'(beats_c) * TPB_W'(div_c);
  assign next_w = (TPB_W'(next_r) >= tpb_c) ? '0 : next_r;
  assign last_w = (TPB_W'(last_r) >= tpb_c) ? '0 : last_r;
  assign spt_x  = $signed({{(CD_W - SPT_W){1'b0}}, spt_r});
  assign cd_cl  = (cd_r > spt_x) ? spt_x : cd_r;

  // Tick firing: the divider holds the beat and sub-beat of next_r.
  assign fire     = cd_r[CD_W-1] || (cd_r == '0);
  assign pat_sh   = pat_r >> {dsp.quot[3:0], 1'b0};
  assign next_inc = TPB_W'(next_r) + 1'b1;
  assign last_new = fire ? next_r : last_r;

  always_comb begin
    if (dsp.rem != '0) begin
      kind_c = KIND_SUB;
    end else if (dsp.quot[DVD_W-1:4] != '0) begin
      kind_c = KIND_NONE;
    end else begin
      kind_c = {1'b0, pat_sh[1:0]};
    end
  end

  assign cd_x   = {{(SUM_W - CD_W){cd_r[CD_W-1]}}, cd_r};
  assign add_x  = fire ? {{(SUM_W - SPT_W){1'b0}}, spt_r} : '0;
  assign cd_sum = cd_x + add_x - CD_DEC;
  assign cd_sat = $signed(cd_sum) < $signed(CD_MIN_X);

  // The countdown is non-negative and below the period when this is used.
  assign frac_a = spt_r - cd_r[SPT_W-1:0];
  assign frac_c = (dsp.quot > DVD_W'(PHASE_ONE)) ? PHASE_ONE : dsp.quot[PH_W:0];

  always_comb begin
    state_nxt     = state_r;
    prev_en_nxt   = prev_en_r;
    next_nxt      = next_r;
    last_nxt      = last_r;
    cd_nxt        = cd_r;
    en_nxt        = en_r;
    div_nxt       = div_r;
    tpb_nxt       = tpb_r;
    m_nxt         = m_r;
    res_run_nxt   = res_run_r;
    res_fired_nxt = res_fired_r;
    res_kind_nxt  = res_kind_r;
    res_beat_nxt  = res_beat_r;
    res_phase_nxt = res_phase_r;
    dreq_nxt      = '0;
    out_load      = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          en_nxt      = in_enable;
          prev_en_nxt = in_enable;
          if (restart) begin
            next_nxt = '0;
            last_nxt = '0;
            cd_nxt   = '0;
          end
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        if (stopped) begin
          res_run_nxt   = 1'b0;
          res_fired_nxt = 1'b0;
          res_kind_nxt  = KIND_NONE;
          res_beat_nxt  = '0;
          res_phase_nxt = '0;
          state_nxt     = ST_OUT;
        end else begin
          div_nxt           = div_c;
          tpb_nxt           = tpb_c;
          next_nxt          = next_w;
          last_nxt          = last_w;
          cd_nxt            = cd_cl;
          res_run_nxt       = 1'b1;
          dreq_nxt.start    = 1'b1;
          dreq_nxt.dividend = DVD_W'(next_w) << (DVD_W - TICK_W);
          dreq_nxt.nbits    = CNT_W'(TICK_W);
          dreq_nxt.divisor  = SPT_W'(div_c);
          state_nxt         = ST_DIVN;
        end
      end
      ST_DIVN: begin
        if (dsp.done) begin
          state_nxt = ST_FIRE;
        end
      end
      ST_FIRE: begin
        res_fired_nxt = fire;
        res_kind_nxt  = fire ? kind_c : KIND_NONE;
        if (fire) begin
          last_nxt = next_r;
          next_nxt = (next_inc == tpb_r) ? '0 : next_inc[TICK_W-1:0];
        end
        cd_nxt            = cd_sat ? $signed(CD_MIN) : $signed(cd_sum[CD_W-1:0]);
        dreq_nxt.start    = 1'b1;
        dreq_nxt.dividend = DVD_W'(last_new) << (DVD_W - TICK_W);
        dreq_nxt.nbits    = CNT_W'(TICK_W);
        dreq_nxt.divisor  = SPT_W'(div_r);
        state_nxt         = ST_DIVL;
      end
      ST_DIVL: begin
        if (dsp.done) begin
          res_beat_nxt   = dsp.quot[mts_pkg::BEATNUM_W-1:0];
          m_nxt          = dsp.rem[DIV_W-1:0];
          dreq_nxt.start = 1'b1;
          if (cd_r[CD_W-1]) begin
            // Past the tick already: the fraction is a full tick.
            dreq_nxt.dividend = (DVD_W'(dsp.rem[DIV_W-1:0]) << PH_W) + DVD_W'(PHASE_ONE);
            dreq_nxt.nbits    = CNT_W'(DVD_W);
            dreq_nxt.divisor  = SPT_W'(div_r);
            state_nxt         = ST_PHASE;
          end else begin
            // Preloading half the numerator leaves 17 quotient bits to find.
            dreq_nxt.rem_init = {1'b0, frac_a[SPT_W-1:1]};
            dreq_nxt.dividend = {frac_a[0], {(DVD_W - 1){1'b0}}};
            dreq_nxt.nbits    = CNT_W'(PH_W + 1);
            dreq_nxt.divisor  = spt_r;
            state_nxt         = ST_FRAC;
          end
        end
      end
      ST_FRAC: begin
        if (dsp.done) begin
          dreq_nxt.start    = 1'b1;
          dreq_nxt.dividend = (DVD_W'(m_r) << PH_W) + DVD_W'(frac_c);
          dreq_nxt.nbits    = CNT_W'(DVD_W);
          dreq_nxt.divisor  = SPT_W'(div_r);
          state_nxt         = ST_PHASE;
        end
      end
      ST_PHASE: begin
        if (dsp.done) begin
          res_phase_nxt = (dsp.quot > DVD_W'({PH_W{1'b1}})) ? {PH_W{1'b1}} :
                          dsp.quot[PH_W-1:0];
          state_nxt     = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      prev_en_r   <= 1'b0;
      next_r      <= '0;
      last_r      <= '0;
      cd_r        <= '0;
      out_valid_r <= 1'b0;
      dreq_r      <= '0;
      beats_cfg_r <= mts_pkg::BEATS_RST;
      div_cfg_r   <= mts_pkg::SUBDIV_RST;
      spt_r       <= mts_pkg::SPT_RST;
      pat_r       <= mts_pkg::PATTERN_RST;
    end else begin
      state_r     <= state_nxt;
      prev_en_r   <= prev_en_nxt;
      next_r      <= next_nxt;
      last_r      <= last_nxt;
      cd_r        <= cd_nxt;
      out_valid_r <= out_valid_nxt;
      dreq_r      <= dreq_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          mts_pkg::CFG_BEATS:   beats_cfg_r <= cfg_data[mts_pkg::BPB_W-1:0];
          mts_pkg::CFG_SUBDIV:  div_cfg_r   <= cfg_data[mts_pkg::SUBDIV_W-1:0];
          mts_pkg::CFG_SPT:     spt_r       <= cfg_data[SPT_W-1:0];
          mts_pkg::CFG_PATTERN: pat_r       <= cfg_data[mts_pkg::PAT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    en_r        <= en_nxt;
    div_r       <= div_nxt;
    tpb_r       <= tpb_nxt;
    m_r         <= m_nxt;
    res_run_r   <= res_run_nxt;
    res_fired_r <= res_fired_nxt;
    res_kind_r  <= res_kind_nxt;
    res_beat_r  <= res_beat_nxt;
    res_phase_r <= res_phase_nxt;
    if (out_load) begin
      out_run_r   <= res_run_r;
      out_fired_r <= res_fired_r;
      out_kind_r  <= res_kind_r;
      out_beat_r  <= res_beat_r;
      out_phase_r <= res_phase_r;
    end
  end

  mts_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq_r),
    .rsp   (dsp)
  );

  assign out_valid       = out_valid_r;
  assign out_running     = out_run_r;
  assign out_fired       = out_fired_r;
  assign out_click_kind  = out_kind_r;
  assign out_beat_number = out_beat_r;
  assign out_beat_phase  = out_phase_r;

  `ASSERT_ALWAYS(a_fired_running, (out_valid_r && out_fired_r) |-> out_run_r,
    "tick fired while stopped")
  `ASSERT_ALWAYS(a_kind_fired, (out_valid_r && out_kind_r != KIND_NONE) |-> out_fired_r,
    "click without tick")
  `ASSERT_ALWAYS(a_div_launch, dreq_r.start |-> (state_r == ST_DIVN || state_r == ST_DIVL ||
    state_r == ST_FRAC || state_r == ST_PHASE), "divider launched outside a wait state")

endmodule

`default_nettype wire

### hw/rtl/mts_div.sv
`default_nettype none

`include "assert_macros.svh"

// Restoring divider, one quotient bit per cycle. The dividend bits are shifted
// in MSB first on top of a preloaded partial remainder, which must be below
// the divisor.
module mts_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire mts_pkg::div_req_t req,
  output mts_pkg::div_rsp_t      rsp
);

  logic                              busy_r;
  logic                              done_r;
  logic [mts_pkg::CNT_W-1:0]         cnt_r;
  logic [mts_pkg::SPT_W-1:0]         rem_r;
  logic [mts_pkg::SPT_W-1:0]         dsr_r;
  logic [mts_pkg::DVD_W-1:0]         dvd_r;
  logic [mts_pkg::DVD_W-1:0]         quo_r;
  logic [mts_pkg::SPT_W:0]           shifted;
  logic [mts_pkg::SPT_W:0]           diff;
  logic                              ge;

  assign shifted = {rem_r, dvd_r[mts_pkg::DVD_W-1]};
  assign ge      = shifted >= {1'b0, dsr_r};
  assign diff    = shifted - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.nbits;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == mts_pkg::CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.rem_init;
      dvd_r <= req.dividend;
      dsr_r <= req.divisor;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[mts_pkg::SPT_W-1:0] : shifted[mts_pkg::SPT_W-1:0];
      dvd_r <= {dvd_r[mts_pkg::DVD_W-2:0], 1'b0};
      quo_r <= {quo_r[mts_pkg::DVD_W-2:0], ge};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;
  assign rsp.rem  = rem_r;

  `ASSERT_ALWAYS(a_rem_below_divisor, busy_r |-> (rem_r < dsr_r), "partial remainder not below divisor")
  `ASSERT_ALWAYS(a_no_restart_busy, req.start |-> !busy_r, "divider started while busy")
  `ASSERT_NEXT(a_start_busy, req.start, busy_r && !done_r, "divider did not start")

endmodule

`default_nettype wire
